/* rtl/gbs_pkg.sv */
// Package for the greedy box suppression unit.
// Beat types, register indexes and state codes; no dependencies.
package gbs_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH = 17;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_OVERLAP_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COORD_OFFSET      = 1'd1;

   localparam logic [16:0] THRESHOLD_RESET = 17'd32768;

   typedef struct packed {
      logic [15:0] box_index;
      logic [15:0] corner_x1;
      logic [15:0] corner_y1;
      logic [15:0] corner_x2;
      logic [15:0] corner_y2;
      logic [31:0] box_area;
      logic        last_box;
   } req_beat_type;

   typedef struct packed {
      logic        kept;
      logic [15:0] kept_index;
      logic [10:0] kept_total;
      logic        set_done;
      logic        store_overflow;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Result of one compare stage back to the sequencer.
   typedef struct packed {
      logic valid;
      logic hit;
   } cmp_status_type;

endpackage

/* rtl/greedy_box_suppression_unit.sv */
// Top level of the greedy box suppression unit.
// Uses gbs_pkg, gbs_ram, gbs_compare and gbs_sequencer.
//
// One box is taken per command while busy is low. The box is compared with
// every kept box of the set, one store entry per cycle, through a pipeline
// of RAM read, extents, intersection and products, until an entry suppresses
// it. The next box can be taken only after the result. The result appears
// for one cycle on rsp_valid and must be taken then. A last box clears the
// store after its result. No clearing pass after reset.
module greedy_box_suppression_unit #(
   parameter int unsigned MAX_KEPT   = 1024,
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  gbs_pkg::req_beat_type                   req_beat,
   output logic                                    rsp_valid,
   output gbs_pkg::rsp_beat_type                   rsp_beat,
   input  logic                                    csr_write,
   input  logic [gbs_pkg::CSR_ADDR_WIDTH-1:0]      csr_index,
   input  logic [gbs_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   localparam int unsigned AW = $clog2(MAX_KEPT);
   localparam int unsigned CBW = 4 * COORD_BITS;

   logic [16:0] threshold_ff;
   logic        offset_ff;
   gbs_pkg::req_beat_type box_ff;
   logic        accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gbs_pkg::THRESHOLD_RESET;
         offset_ff    <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            gbs_pkg::REG_OVERLAP_THRESHOLD: threshold_ff <= csr_data[16:0];
            gbs_pkg::REG_COORD_OFFSET:      offset_ff    <= csr_data[0];
            default: ;
         endcase
      end
      if (accept) box_ff <= req_beat;
   end

   logic [COORD_BITS-1:0] ax1, ay1, ax2, ay2;
   assign ax1 = COORD_BITS'(box_ff.corner_x1);
   assign ay1 = COORD_BITS'(box_ff.corner_y1);
   assign ax2 = COORD_BITS'(box_ff.corner_x2);
   assign ay2 = COORD_BITS'(box_ff.corner_y2);

   logic          rd_issue, wr_en, done, kept, overflow;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [10:0]   total;
   logic [CBW-1:0] corners_rd;
   logic [31:0]   area_rd;
   logic          rd_valid_ff;
   gbs_pkg::cmp_status_type status;

   gbs_ram #(.WIDTH(CBW), .DEPTH(MAX_KEPT)) u_corner_ram (
      .clock, .wr_en, .wr_addr,
      .wr_data ({ax1, ay1, ax2, ay2}),
      .rd_addr, .rd_data (corners_rd));

   gbs_ram #(.WIDTH(32), .DEPTH(MAX_KEPT)) u_area_ram (
      .clock, .wr_en, .wr_addr,
      .wr_data (box_ff.box_area),
      .rd_addr, .rd_data (area_rd));

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else       rd_valid_ff <= rd_issue;
   end

   gbs_compare #(.COORD_BITS(COORD_BITS)) u_compare (
      .clock, .reset,
      .in_valid (rd_valid_ff),
      .a_x1 (ax1), .a_y1 (ay1), .a_x2 (ax2), .a_y2 (ay2),
      .a_area (box_ff.box_area),
      .b_x1 (corners_rd[4*COORD_BITS-1:3*COORD_BITS]),
      .b_y1 (corners_rd[3*COORD_BITS-1:2*COORD_BITS]),
      .b_x2 (corners_rd[2*COORD_BITS-1:COORD_BITS]),
      .b_y2 (corners_rd[COORD_BITS-1:0]),
      .b_area (area_rd),
      .coord_offset (offset_ff),
      .threshold (threshold_ff),
      .status);

   gbs_sequencer #(.MAX_KEPT(MAX_KEPT)) u_seq (
      .clock, .reset, .start,
      .last_box (req_beat.last_box),
      .status, .busy, .rd_issue, .rd_addr, .wr_en, .wr_addr,
      .done, .kept, .overflow, .total);

   assign rsp_valid               = done;
   assign rsp_beat.kept           = kept;
   assign rsp_beat.kept_index     = box_ff.box_index;
   assign rsp_beat.kept_total     = total;
   assign rsp_beat.set_done       = box_ff.last_box;
   assign rsp_beat.store_overflow = overflow;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");
   a_no_write_on_hit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> rsp_valid && rsp_beat.kept && !rsp_beat.store_overflow)
      else $error("store write without kept result");

endmodule

/* rtl/gbs_ram.sv */
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module gbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gbs_compare.sv */
// Overlap test pipeline: one stored box against the current box.
// Uses gbs_pkg. Three register stages: extents, intersection, products.
module gbs_compare #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [COORD_BITS-1:0]   a_x1,
   input  logic [COORD_BITS-1:0]   a_y1,
   input  logic [COORD_BITS-1:0]   a_x2,
   input  logic [COORD_BITS-1:0]   a_y2,
   input  logic [31:0]             a_area,
   input  logic [COORD_BITS-1:0]   b_x1,
   input  logic [COORD_BITS-1:0]   b_y1,
   input  logic [COORD_BITS-1:0]   b_x2,
   input  logic [COORD_BITS-1:0]   b_y2,
   input  logic [31:0]             b_area,
   input  logic                    coord_offset,
   input  logic [16:0]             threshold,
   output gbs_pkg::cmp_status_type status
);

   localparam int unsigned EW = COORD_BITS + 1;   // clamped extent width
   localparam int unsigned PW = 2 * EW;           // raw product width
   localparam int unsigned XW = (PW > 41) ? PW : 41;
   localparam logic [XW-1:0] INTER_CAP = XW'(64'd1 << 40);

   logic [EW-1:0] w_in, h_in, w_ff, h_ff;
   logic [32:0]   asum_in, asum_ff;
   logic          v1_ff, v2_ff, v3_ff;
   logic [40:0]   inter_in, inter_ff;
   logic [34:0]   uni_in, uni_ff;            // signed
   logic [56:0]   lhs_ff;
   logic [50:0]   rhs_ff;
   logic          upos_ff, ipos_ff;
   logic [PW-1:0] prod;

   function automatic logic [COORD_BITS:0] extent(
      input logic [COORD_BITS-1:0] p1, input logic [COORD_BITS-1:0] p2,
      input logic [COORD_BITS-1:0] q1, input logic [COORD_BITS-1:0] q2,
      input logic off);
      logic [COORD_BITS-1:0] lo, hi;
      logic [COORD_BITS+1:0] e;
      lo = (p1 > q1) ? p1 : q1;
      hi = (p2 < q2) ? p2 : q2;
      e = {2'b00, hi} - {2'b00, lo} + (off ? (COORD_BITS+2)'(16) : '0);
      return e[COORD_BITS+1] ? '0 : e[COORD_BITS:0];
   endfunction

   always_comb begin
      w_in = extent(a_x1, a_x2, b_x1, b_x2, coord_offset);
      h_in = extent(a_y1, a_y2, b_y1, b_y2, coord_offset);
      asum_in = {1'b0, a_area} + {1'b0, b_area};
   end

   assign prod = PW'(w_ff) * PW'(h_ff);

   always_comb begin
      if (XW'(prod) > INTER_CAP) begin
         inter_in = 41'd1 << 40;
      end else begin
         inter_in = 41'(prod);
      end
      uni_in = {2'b00, asum_ff} - {1'b0, 34'(inter_in)};
   end

   // Suppression from stage 3 registers
   logic hit;
   always_comb begin
      if (!upos_ff) begin
         hit = ipos_ff;
      end else begin
         hit = lhs_ff >= 57'(rhs_ff);
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      h_ff     <= h_in;
      asum_ff  <= asum_in;
      inter_ff <= inter_in;
      uni_ff   <= uni_in;
      lhs_ff   <= {inter_ff, 16'd0};
      rhs_ff   <= 51'(threshold) * 51'(uni_ff[33:0]);
      upos_ff  <= !uni_ff[34] && (uni_ff != '0);
      ipos_ff  <= inter_ff != '0;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign status.valid = v3_ff;
   assign status.hit   = hit;

   a_hit_needs_valid: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v2_ff))
      else $error("compare result without stage 2 beat");
   a_no_valid_from_nothing: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("stage 2 beat without stage 1 beat");
   a_uni_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff && upos_ff |-> rhs_ff <= {17'h1FFFF, 34'h3FFFFFFFF})
      else $error("union product out of range");

endmodule

/* rtl/gbs_sequencer.sv */
// Scan sequencer: walks the kept store, collects hits, writes back kept boxes.
// Uses gbs_pkg.
module gbs_sequencer #(
   parameter int unsigned MAX_KEPT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        last_box,
   input  gbs_pkg::cmp_status_type     status,
   output logic                        busy,
   output logic                        rd_issue,
   output logic [$clog2(MAX_KEPT)-1:0] rd_addr,
   output logic                        wr_en,
   output logic [$clog2(MAX_KEPT)-1:0] wr_addr,
   output logic                        done,
   output logic                        kept,
   output logic                        overflow,
   output logic [10:0]                 total
);

   localparam int unsigned AW = $clog2(MAX_KEPT);
   localparam int unsigned CW = $clog2(MAX_KEPT + 1);
   localparam int unsigned PIPE = 4;   // RAM read plus three compare stages

   gbs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic [CW-1:0] back_ff, back_in;
   logic          hit_ff, hit_in;
   logic          last_ff, last_in;
   logic          scan_end;

   assign scan_end = (back_ff == count_ff) || hit_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbs_pkg::ST_IDLE: if (start) state_in = gbs_pkg::ST_SCAN;
         gbs_pkg::ST_SCAN: if (scan_end && issued_ff == back_ff)
            state_in = gbs_pkg::ST_DONE;
         gbs_pkg::ST_DONE: state_in = gbs_pkg::ST_IDLE;
         default:          state_in = gbs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      issued_in = issued_ff;
      back_in   = back_ff;
      hit_in    = hit_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      rd_issue  = 1'b0;
      wr_en     = 1'b0;
      done      = 1'b0;
      case (state_ff)
         gbs_pkg::ST_IDLE: begin
            issued_in = '0;
            back_in   = '0;
            hit_in    = 1'b0;
            if (start) last_in = last_box;
         end
         gbs_pkg::ST_SCAN: begin
            if (!hit_ff && issued_ff != count_ff) begin
               rd_issue  = 1'b1;
               issued_in = issued_ff + 1'b1;
            end
            if (status.valid) begin
               back_in = back_ff + 1'b1;
               if (status.hit) hit_in = 1'b1;
            end
         end
         gbs_pkg::ST_DONE: begin
            done = 1'b1;
            if (!hit_ff && count_ff != CW'(MAX_KEPT)) begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (last_ff) count_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gbs_pkg::ST_IDLE;
         count_ff  <= '0;
         issued_ff <= '0;
         back_ff   <= '0;
         hit_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issued_ff <= issued_in;
         back_ff   <= back_in;
         hit_ff    <= hit_in;
         last_ff   <= last_in;
      end
   end

   assign busy     = state_ff != gbs_pkg::ST_IDLE;
   assign rd_addr  = issued_ff[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];
   assign kept     = !hit_ff;
   assign overflow = !hit_ff && count_ff == CW'(MAX_KEPT);
   assign total    = (!hit_ff && count_ff != CW'(MAX_KEPT)) ?
                     11'(count_ff + 1'b1) : 11'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEPT))
      else $error("kept count beyond store depth");
   a_back_le_issued: assert property (@(posedge clock) disable iff (reset)
      back_ff <= issued_ff)
      else $error("more compare results than reads");
   a_inflight: assert property (@(posedge clock) disable iff (reset)
      issued_ff - back_ff <= CW'(PIPE))
      else $error("too many reads in flight");
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      done && last_ff |=> count_ff == '0)
      else $error("store not cleared after last box");

endmodule
